FILE: rtl/ptmap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmap_pkg
// Shared types and constants of the four-level page table mapper.
// ----------------------------------------------------------------------------
package ptmap_pkg;

    // Default number of 4 KB table pages in the local memory
    localparam int MEM_PAGES_DEF = 64;

    // Table geometry
    localparam int IDX_W          = 9;
    localparam int WORDS_PER_PAGE = 512;
    localparam int PAGE_SHIFT     = 12;
    localparam int ENTRY_W        = 64;
    localparam int LEVEL_W        = 2;

    // Request and result field widths
    localparam int VA_W        = 48;
    localparam int PA_W        = 52;
    localparam int FLAGS_W     = 12;
    localparam int STATUS_W    = 2;
    localparam int MADE_W      = 2;
    localparam int LEAF_ADDR_W = 24;

    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 96;
    localparam int M_USED_W = STATUS_W + MADE_W + LEAF_ADDR_W + ENTRY_W;

    // Fixed pages
    localparam int ROOT_PAGE       = 1;
    localparam int FIRST_FREE_PAGE = 2;

    // Entry bits
    localparam logic [ENTRY_W-1:0] BIT_PRESENT = 64'h1;
    localparam logic [ENTRY_W-1:0] BIT_WRITE   = 64'h2;
    localparam logic [ENTRY_W-1:0] BIT_USER    = 64'h4;
    localparam logic [ENTRY_W-1:0] TABLE_BITS  = BIT_PRESENT | BIT_WRITE | BIT_USER;

    // Walk depth: index of the last upper level (PD)
    localparam logic [LEVEL_W-1:0] LAST_UPPER_LEVEL = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_VMIS = 2'd1,
        ST_FMIS = 2'd2,
        ST_OOM  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_READ_ENTRY,
        MEM_WRITE_ZERO,
        MEM_WRITE_ENTRY,
        MEM_WRITE_LEAF
    } mem_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_ZERO,
        S_LINK,
        S_LEAF,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        mem_op_t mem_op;
        logic    zero_root;
        logic    follow;
        logic    next_level;
        logic    set_status;
        status_t res_status;
        logic    load_out;
    } ptmap_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic vmis;
        logic fmis;
        logic present;
        logic page_oob;
        logic alloc_full;
        logic zero_last;
        logic last_level;
        logic out_full;
    } ptmap_stat_t;

endpackage

FILE: rtl/four_level_page_table_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_core
// Maps 4 KB virtual pages into a four-level table kept in local word memory.
// ----------------------------------------------------------------------------
// After reset the block zeroes its root table page, one word per cycle, with
// s_tready low. It then takes one map request at a time. A request whose
// tables already exist passes through the check, three read/evaluate pairs,
// the leaf write and the result load, and the block then returns to idle to
// take the next request. Each table that has to be created adds 512 zeroing
// writes plus the entry write, all through the one memory port. A misaligned
// request goes from the check straight to the result load. The result register
// lets the next request start while a result waits on m_tready.
module four_level_page_table_mapper_core
#(
    parameter int MEM_PAGES = ptmap_pkg::MEM_PAGES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // virt_page[47:0], phys_frame[99:48], map_flags[111:100]
    input  logic [ptmap_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], tables_created[3:2], leaf_entry_addr[27:4],
    // leaf_entry_value[91:28], zero[95:92]
    output logic [ptmap_pkg::M_DATA_W-1:0]   m_tdata
);

    ptmap_pkg::ptmap_cmd_t  cmd;
    ptmap_pkg::ptmap_stat_t stat;

    ptmap_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptmap_datapath
    #(
        .MEM_PAGES (MEM_PAGES)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (s_tdata),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: rtl/ptmap_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmap_ctrl
// Walk sequencer: root clearing pass, level walk, table allocation, leaf write.
// ----------------------------------------------------------------------------
module ptmap_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  ptmap_pkg::ptmap_stat_t stat,
    output ptmap_pkg::ptmap_cmd_t  cmd
);

    ptmap_pkg::state_t state_reg;
    ptmap_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptmap_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptmap_pkg::S_CLEAR:
            begin
                if (stat.zero_last)
                begin
                    state_next = ptmap_pkg::S_IDLE;
                end
            end
            ptmap_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ptmap_pkg::S_CHECK;
                end
            end
            ptmap_pkg::S_CHECK:
            begin
                if (stat.vmis || stat.fmis)
                begin
                    state_next = ptmap_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ptmap_pkg::S_READ;
                end
            end
            ptmap_pkg::S_READ:
            begin
                if (stat.page_oob)
                begin
                    state_next = ptmap_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ptmap_pkg::S_EVAL;
                end
            end
            ptmap_pkg::S_EVAL:
            begin
                priority if (stat.present)
                begin
                    state_next = stat.last_level ? ptmap_pkg::S_LEAF : ptmap_pkg::S_READ;
                end
                else if (stat.alloc_full)
                begin
                    state_next = ptmap_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ptmap_pkg::S_ZERO;
                end
            end
            ptmap_pkg::S_ZERO:
            begin
                if (stat.zero_last)
                begin
                    state_next = ptmap_pkg::S_LINK;
                end
            end
            ptmap_pkg::S_LINK:
            begin
                state_next = stat.last_level ? ptmap_pkg::S_LEAF : ptmap_pkg::S_READ;
            end
            ptmap_pkg::S_LEAF:
            begin
                state_next = ptmap_pkg::S_FINISH;
            end
            ptmap_pkg::S_FINISH:
            begin
                if (!stat.out_full)
                begin
                    state_next = ptmap_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptmap_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mem_op     = ptmap_pkg::MEM_IDLE;
        cmd.res_status = ptmap_pkg::ST_OK;
        req_ready      = 1'b0;
        unique case (state_reg)
            ptmap_pkg::S_CLEAR:
            begin
                cmd.mem_op    = ptmap_pkg::MEM_WRITE_ZERO;
                cmd.zero_root = 1'b1;
            end
            ptmap_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ptmap_pkg::S_CHECK:
            begin
                priority if (stat.vmis)
                begin
                    cmd.set_status = 1'b1;
                    cmd.res_status = ptmap_pkg::ST_VMIS;
                end
                else if (stat.fmis)
                begin
                    cmd.set_status = 1'b1;
                    cmd.res_status = ptmap_pkg::ST_FMIS;
                end
                else
                begin
                    cmd.set_status = 1'b0;
                end
            end
            ptmap_pkg::S_READ:
            begin
                if (stat.page_oob)
                begin
                    cmd.set_status = 1'b1;
                    cmd.res_status = ptmap_pkg::ST_OOM;
                end
                else
                begin
                    cmd.mem_op = ptmap_pkg::MEM_READ_ENTRY;
                end
            end
            ptmap_pkg::S_EVAL:
            begin
                priority if (stat.present)
                begin
                    cmd.follow     = 1'b1;
                    cmd.next_level = !stat.last_level;
                end
                else if (stat.alloc_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.res_status = ptmap_pkg::ST_OOM;
                end
                else
                begin
                    cmd.follow = 1'b0;
                end
            end
            ptmap_pkg::S_ZERO:
            begin
                cmd.mem_op = ptmap_pkg::MEM_WRITE_ZERO;
            end
            ptmap_pkg::S_LINK:
            begin
                cmd.mem_op     = ptmap_pkg::MEM_WRITE_ENTRY;
                cmd.next_level = !stat.last_level;
            end
            ptmap_pkg::S_LEAF:
            begin
                if (stat.page_oob)
                begin
                    cmd.set_status = 1'b1;
                    cmd.res_status = ptmap_pkg::ST_OOM;
                end
                else
                begin
                    cmd.mem_op = ptmap_pkg::MEM_WRITE_LEAF;
                end
            end
            ptmap_pkg::S_FINISH:
            begin
                cmd.load_out = !stat.out_full;
            end
            default:
            begin
                cmd.load_out = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/ptmap_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmap_datapath
// Request registers, table word memory, page allocator and result register.
// ----------------------------------------------------------------------------
module ptmap_datapath
#(
    parameter int MEM_PAGES = ptmap_pkg::MEM_PAGES_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [ptmap_pkg::S_DATA_W-1:0]       req_data,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [ptmap_pkg::M_DATA_W-1:0]       res_data,
    input  ptmap_pkg::ptmap_cmd_t                cmd,
    output ptmap_pkg::ptmap_stat_t               stat
);

    localparam int PAGE_W    = $clog2(MEM_PAGES + 1);
    localparam int MEM_WORDS = MEM_PAGES * ptmap_pkg::WORDS_PER_PAGE;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int PIDX_W    = ADDR_W - ptmap_pkg::IDX_W;
    localparam int NXT_W     = ptmap_pkg::PA_W - ptmap_pkg::PAGE_SHIFT;

    localparam logic [PAGE_W-1:0] PAGE_LIMIT = PAGE_W'(MEM_PAGES);

    // Request fields
    logic [ptmap_pkg::VA_W-1:0]    va_reg;
    logic [ptmap_pkg::PA_W-1:0]    pa_reg;
    logic [ptmap_pkg::FLAGS_W-1:0] flags_reg;

    // Walk state
    logic [ptmap_pkg::LEVEL_W-1:0] level_reg;
    logic [PAGE_W-1:0]             page_reg;
    logic [PAGE_W-1:0]             free_page_reg;
    logic [ptmap_pkg::MADE_W-1:0]  made_reg;
    logic [ptmap_pkg::IDX_W-1:0]   zero_cnt_reg;
    ptmap_pkg::status_t            code_reg;
    logic [ptmap_pkg::LEAF_ADDR_W-1:0] leaf_addr_reg;
    logic [ptmap_pkg::ENTRY_W-1:0]     leaf_value_reg;

    // Memory
    logic [ptmap_pkg::ENTRY_W-1:0] mem [0:MEM_WORDS-1];
    logic [ptmap_pkg::ENTRY_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]             mem_addr;
    logic [ptmap_pkg::ENTRY_W-1:0] mem_wdata;
    logic                          mem_we;

    // Result register
    logic                                  out_valid_reg;
    logic [ptmap_pkg::M_DATA_W-1:0]        out_data_reg;

    logic [ptmap_pkg::IDX_W-1:0]   level_idx;
    logic [ptmap_pkg::IDX_W-1:0]   leaf_idx;
    logic [PAGE_W-1:0]             zero_page;
    logic [NXT_W-1:0]              entry_page;
    logic [PAGE_W-1:0]             follow_page;
    logic [ptmap_pkg::ENTRY_W-1:0] link_entry;
    logic [ptmap_pkg::ENTRY_W-1:0] leaf_entry;
    logic [ptmap_pkg::LEAF_ADDR_W-1:0] leaf_addr;

    always_comb
    begin
        unique case (level_reg)
            2'd0:    level_idx = va_reg[47:39];
            2'd1:    level_idx = va_reg[38:30];
            2'd2:    level_idx = va_reg[29:21];
            default: level_idx = va_reg[20:12];
        endcase
    end

    assign leaf_idx   = va_reg[20:12];
    assign zero_page  = cmd.zero_root ? PAGE_W'(ptmap_pkg::ROOT_PAGE) : free_page_reg;
    assign entry_page = rdata_reg[ptmap_pkg::PA_W-1:ptmap_pkg::PAGE_SHIFT];
    // Clamp a pointer past the memory to the limit so the next level flags it
    assign follow_page = (entry_page >= NXT_W'(MEM_PAGES)) ? PAGE_LIMIT
                                                            : entry_page[PAGE_W-1:0];
    assign link_entry = (ptmap_pkg::ENTRY_W'(free_page_reg) << ptmap_pkg::PAGE_SHIFT)
                        | ptmap_pkg::TABLE_BITS;
    assign leaf_entry = ptmap_pkg::ENTRY_W'(pa_reg) | ptmap_pkg::ENTRY_W'(flags_reg)
                        | ptmap_pkg::BIT_PRESENT;
    assign leaf_addr  = (ptmap_pkg::LEAF_ADDR_W'(page_reg) << ptmap_pkg::PAGE_SHIFT)
                        | ptmap_pkg::LEAF_ADDR_W'({leaf_idx, 3'b000});

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_addr  = {page_reg[PIDX_W-1:0], level_idx};
        unique case (cmd.mem_op)
            ptmap_pkg::MEM_IDLE:
            begin
                mem_we = 1'b0;
            end
            ptmap_pkg::MEM_READ_ENTRY:
            begin
                mem_we = 1'b0;
            end
            ptmap_pkg::MEM_WRITE_ZERO:
            begin
                mem_we   = 1'b1;
                mem_addr = {zero_page[PIDX_W-1:0], zero_cnt_reg};
            end
            ptmap_pkg::MEM_WRITE_ENTRY:
            begin
                mem_we    = 1'b1;
                mem_wdata = link_entry;
            end
            ptmap_pkg::MEM_WRITE_LEAF:
            begin
                mem_we    = 1'b1;
                mem_wdata = leaf_entry;
                mem_addr  = {page_reg[PIDX_W-1:0], leaf_idx};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_op == ptmap_pkg::MEM_READ_ENTRY)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Request payload and staged leaf result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            va_reg         <= req_data[47:0];
            pa_reg         <= req_data[99:48];
            flags_reg      <= req_data[111:100];
            leaf_addr_reg  <= '0;
            leaf_value_reg <= '0;
        end
        else if (cmd.mem_op == ptmap_pkg::MEM_WRITE_LEAF)
        begin
            leaf_addr_reg  <= leaf_addr;
            leaf_value_reg <= leaf_entry;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{(ptmap_pkg::M_DATA_W - ptmap_pkg::M_USED_W){1'b0}},
                             leaf_value_reg, leaf_addr_reg, made_reg, code_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            page_reg      <= PAGE_W'(ptmap_pkg::ROOT_PAGE);
            free_page_reg <= PAGE_W'(ptmap_pkg::FIRST_FREE_PAGE);
            made_reg      <= '0;
            zero_cnt_reg  <= '0;
            code_reg      <= ptmap_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                level_reg <= '0;
                page_reg  <= PAGE_W'(ptmap_pkg::ROOT_PAGE);
                made_reg  <= '0;
                code_reg  <= ptmap_pkg::ST_OK;
            end
            else
            begin
                if (cmd.next_level)
                begin
                    level_reg <= level_reg + 1'b1;
                end
                if (cmd.follow)
                begin
                    page_reg <= follow_page;
                end
                if (cmd.set_status)
                begin
                    code_reg <= cmd.res_status;
                end
                // Hand out the zeroed page and descend into it
                if (cmd.mem_op == ptmap_pkg::MEM_WRITE_ENTRY)
                begin
                    page_reg      <= free_page_reg;
                    free_page_reg <= free_page_reg + 1'b1;
                    made_reg      <= made_reg + 1'b1;
                end
            end
            // Wraps to zero at the end of every page sweep
            if (cmd.mem_op == ptmap_pkg::MEM_WRITE_ZERO)
            begin
                zero_cnt_reg <= zero_cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.vmis       = (va_reg[ptmap_pkg::PAGE_SHIFT-1:0] != '0);
    assign stat.fmis       = (pa_reg[ptmap_pkg::PAGE_SHIFT-1:0] != '0);
    assign stat.present    = rdata_reg[0];
    assign stat.page_oob   = (page_reg >= PAGE_LIMIT);
    assign stat.alloc_full = (free_page_reg >= PAGE_LIMIT);
    assign stat.zero_last  = (zero_cnt_reg == {ptmap_pkg::IDX_W{1'b1}});
    assign stat.last_level = (level_reg == ptmap_pkg::LAST_UPPER_LEVEL);
    assign stat.out_full   = out_valid_reg && !res_ready;

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

FILE: rtl/ptmap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmap_checker
// Port-level checks of the page table mapper, bound to the top level.
// ----------------------------------------------------------------------------
module ptmap_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ptmap_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [ptmap_pkg::STATUS_W-1:0] res_status;

    assign res_status = m_tdata[1:0];

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while walk busy");

    // Rejected requests create no tables and report no leaf
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res_status == ptmap_pkg::ST_VMIS || res_status == ptmap_pkg::ST_FMIS)
        |-> m_tdata[91:2] == '0)
        else $error("rejected request reports work");

    // Failed walks report no leaf, successful ones a present leaf
    a_leaf_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_status == ptmap_pkg::ST_OK) ? m_tdata[28]
                                                      : (m_tdata[91:4] == '0))
        else $error("leaf fields disagree with status");

    // Padding stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[95:92] == '0)
        else $error("result padding not zero");

endmodule

bind four_level_page_table_mapper_core ptmap_checker u_ptmap_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
